// ===== rtl/stbdm_pkg.sv =====
package stbdm_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned ZoneWidth    = 7;
   localparam int unsigned PercentWidth = 7;
   localparam int unsigned CtrlWidth    = 6;
   localparam int unsigned ProdWidth    = ByteWidth + PercentWidth;
   localparam int unsigned RecipShift   = 18;
   localparam int unsigned RecipWidth   = ProdWidth + 13;
   localparam int unsigned CsrIdxWidth  = 2;

   localparam logic [ByteWidth-1:0]    StickCentre  = 8'd127;
   localparam logic [ZoneWidth-1:0]    ZoneReset    = 7'd30;
   localparam logic [PercentWidth-1:0] PercentReset = 7'd60;
   localparam logic [ByteWidth-1:0]    HeaderReset  = 8'd173;
   localparam logic [ByteWidth-1:0]    SpeedMax     = 8'd255;
   localparam int unsigned             SwapBit      = 3;

   // ceil(2^18 / 50): x*2/100 == x/50, exact for x below 2^15
   localparam logic [RecipWidth-1:0]   Div50Recip   = 28'd5243;

   // directions released, horn on, enable low
   localparam logic [CtrlWidth-1:0]    CtrlIdle     = 6'h3B;
   localparam int unsigned             OneFwdBit    = 0;
   localparam int unsigned             OneRevBit    = 3;
   localparam int unsigned             TwoFwdBit    = 4;
   localparam int unsigned             TwoRevBit    = 5;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEAD_ZONE     = 2'd0,
      CSR_SPEED_PERCENT = 2'd1,
      CSR_HEADER_BYTE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ByteWidth-1:0] chan_one;
      logic [ByteWidth-1:0] chan_two;
      logic                 swap;
   } poll_type;

   typedef struct packed {
      logic [ProdWidth-1:0] prod_one;
      logic [ProdWidth-1:0] prod_two;
      logic [CtrlWidth-1:0] ctrl;
   } scaled_type;

endpackage

// ===== rtl/stbdm_capture.sv =====
module stbdm_capture
   import stbdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_button_byte,
   input  logic [ByteWidth-1:0] req_first_stick,
   input  logic [ByteWidth-1:0] req_second_stick,
   input  logic                 down_ready,
   output logic                 poll_valid,
   output poll_type             poll
);

   logic     valid_ff, valid_in;
   logic     swap_ff, swap_in;
   logic     prev_ff, prev_in;
   poll_type poll_ff, poll_in;
   logic     accept, pressed, has_sticks;

   assign req_stall  = valid_ff && !down_ready;
   assign accept     = req_valid && !req_stall;
   assign pressed    = req_button_byte[SwapBit];
   assign has_sticks = (req_first_stick != '0) || (req_second_stick != '0);

   always_comb begin
      swap_in  = swap_ff;
      prev_in  = prev_ff;
      valid_in = valid_ff;
      poll_in  = poll_ff;
      if (accept) begin
         if (pressed && !prev_ff) begin
            swap_in = !swap_ff;
         end
         if (has_sticks) begin
            prev_in = pressed;
         end
         valid_in = has_sticks;
         // exchange channels up front in swap mode
         poll_in.swap     = swap_in;
         poll_in.chan_one = swap_in ? req_second_stick : req_first_stick;
         poll_in.chan_two = swap_in ? req_first_stick : req_second_stick;
      end else if (down_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         swap_ff  <= 1'b0;
         prev_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         swap_ff  <= swap_in;
         prev_ff  <= prev_in;
      end
      poll_ff <= poll_in;
   end

   assign poll_valid = valid_ff;
   assign poll       = poll_ff;

endmodule

// ===== rtl/stbdm_scale.sv =====
module stbdm_scale
   import stbdm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ZoneWidth-1:0]    dead_zone,
   input  logic [PercentWidth-1:0] speed_percent,
   input  logic                    poll_valid,
   input  poll_type                poll,
   output logic                    up_ready,
   input  logic                    down_ready,
   output logic                    scaled_valid,
   output scaled_type              scaled
);

   logic                   valid_ff, valid_in;
   scaled_type             scaled_ff, scaled_in;
   logic [ByteWidth-1:0]   zone_lo;
   logic [ByteWidth:0]     zone_hi;
   logic [ByteWidth-1:0]   mag_one, mag_two;
   logic                   low_one, high_one, low_two, high_two;

   assign up_ready = !valid_ff || down_ready;

   assign zone_lo  = StickCentre - {1'b0, dead_zone};
   assign zone_hi  = {1'b0, StickCentre} + {2'b00, dead_zone};

   assign low_one  = poll.chan_one < zone_lo;
   assign high_one = {1'b0, poll.chan_one} > zone_hi;
   assign low_two  = poll.chan_two < zone_lo;
   assign high_two = {1'b0, poll.chan_two} > zone_hi;

   assign mag_one = (poll.chan_one >= StickCentre) ? poll.chan_one - StickCentre
                                                   : StickCentre - poll.chan_one;
   assign mag_two = (poll.chan_two >= StickCentre) ? poll.chan_two - StickCentre
                                                   : StickCentre - poll.chan_two;

   always_comb begin
      scaled_in.prod_one = ProdWidth'(mag_one) * ProdWidth'(speed_percent);
      scaled_in.prod_two = ProdWidth'(mag_two) * ProdWidth'(speed_percent);
      scaled_in.ctrl     = CtrlIdle;
      // swap mode reverses polarity on both bridges
      if (poll.swap ? high_one : low_one) begin
         scaled_in.ctrl[OneRevBit] = 1'b0;
      end
      if (poll.swap ? low_one : high_one) begin
         scaled_in.ctrl[OneFwdBit] = 1'b0;
      end
      if (poll.swap ? high_two : low_two) begin
         scaled_in.ctrl[TwoRevBit] = 1'b0;
      end
      if (poll.swap ? low_two : high_two) begin
         scaled_in.ctrl[TwoFwdBit] = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) begin
         valid_in = poll_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && poll_valid) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled_valid = valid_ff;
   assign scaled       = scaled_ff;

endmodule

// ===== rtl/stbdm_frame.sv =====
module stbdm_frame
   import stbdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ByteWidth-1:0] header_byte,
   input  logic                 scaled_valid,
   input  scaled_type           scaled,
   output logic                 up_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ByteWidth-1:0] rsp_frame_header,
   output logic [ByteWidth-1:0] rsp_first_speed,
   output logic [ByteWidth-1:0] rsp_second_speed,
   output logic [CtrlWidth-1:0] rsp_control_bits
);

   logic                  valid_ff, valid_in;
   logic [ByteWidth-1:0]  header_ff, one_ff, one_in, two_ff, two_in;
   logic [CtrlWidth-1:0]  ctrl_ff;
   logic [RecipWidth-1:0] recip_one, recip_two;
   logic [RecipWidth-RecipShift-1:0] quot_one, quot_two;

   assign up_ready = !valid_ff || !rsp_stall;

   assign recip_one = RecipWidth'(scaled.prod_one) * Div50Recip;
   assign recip_two = RecipWidth'(scaled.prod_two) * Div50Recip;
   assign quot_one  = recip_one[RecipWidth-1:RecipShift];
   assign quot_two  = recip_two[RecipWidth-1:RecipShift];

   assign one_in = (quot_one > {2'b00, SpeedMax}) ? SpeedMax : quot_one[ByteWidth-1:0];
   assign two_in = (quot_two > {2'b00, SpeedMax}) ? SpeedMax : quot_two[ByteWidth-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) begin
         valid_in = scaled_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && scaled_valid) begin
         header_ff <= header_byte;
         one_ff    <= one_in;
         two_ff    <= two_in;
         ctrl_ff   <= scaled.ctrl;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_header = header_ff;
   assign rsp_first_speed  = one_ff;
   assign rsp_second_speed = two_ff;
   assign rsp_control_bits = ctrl_ff;

endmodule

// ===== rtl/stick_to_bridge_drive_mapper_unit.sv =====
// channel  direction  handshake          payload
// req      in         req_valid/stall    button_byte, first_stick, second_stick
// rsp      out        rsp_valid/stall    frame_header, first/second_speed, control_bits
// csr      in         csr_valid/ready    csr_index, csr_data
//
// One poll per cycle while rsp_stall is low; a frame is registered in the capture register,
// then the multiply register, then the divide-by-50 and output register.
// Polls with both sticks zero update the swap toggle and give no frame.
// Reset clears swap mode and button memory and loads the register defaults.
// Each stage holds only while full and blocked, so bubbles close up under stall.
module stick_to_bridge_drive_mapper_unit
   import stbdm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ByteWidth-1:0]   req_button_byte,
   input  logic [ByteWidth-1:0]   req_first_stick,
   input  logic [ByteWidth-1:0]   req_second_stick,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ByteWidth-1:0]   rsp_frame_header,
   output logic [ByteWidth-1:0]   rsp_first_speed,
   output logic [ByteWidth-1:0]   rsp_second_speed,
   output logic [CtrlWidth-1:0]   rsp_control_bits,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_data
);

   logic [ZoneWidth-1:0]    zone_ff;
   logic [PercentWidth-1:0] percent_ff;
   logic [ByteWidth-1:0]    header_ff;
   logic                    poll_valid, scale_ready;
   poll_type                poll;
   logic                    scaled_valid, frame_ready;
   scaled_type              scaled;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff    <= ZoneReset;
         percent_ff <= PercentReset;
         header_ff  <= HeaderReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEAD_ZONE:     zone_ff    <= csr_data[ZoneWidth-1:0];
            CSR_SPEED_PERCENT: percent_ff <= csr_data[PercentWidth-1:0];
            CSR_HEADER_BYTE:   header_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   stbdm_capture u_capture (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_byte  (req_button_byte),
      .req_first_stick  (req_first_stick),
      .req_second_stick (req_second_stick),
      .down_ready       (scale_ready),
      .poll_valid       (poll_valid),
      .poll             (poll)
   );

   stbdm_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .dead_zone     (zone_ff),
      .speed_percent (percent_ff),
      .poll_valid    (poll_valid),
      .poll          (poll),
      .up_ready      (scale_ready),
      .down_ready    (frame_ready),
      .scaled_valid  (scaled_valid),
      .scaled        (scaled)
   );

   stbdm_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .header_byte      (header_ff),
      .scaled_valid     (scaled_valid),
      .scaled           (scaled),
      .up_ready         (frame_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_header (rsp_frame_header),
      .rsp_first_speed  (rsp_first_speed),
      .rsp_second_speed (rsp_second_speed),
      .rsp_control_bits (rsp_control_bits)
   );

endmodule

// ===== test/drive_frame_checker.sv =====
`timescale 1ns / 100ps

module drive_frame_checker
   import stbdm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [ByteWidth-1:0]   req_button_byte,
   input  logic [ByteWidth-1:0]   req_first_stick,
   input  logic [ByteWidth-1:0]   req_second_stick,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [ByteWidth-1:0]   rsp_frame_header,
   input  logic [ByteWidth-1:0]   rsp_first_speed,
   input  logic [ByteWidth-1:0]   rsp_second_speed,
   input  logic [CtrlWidth-1:0]   rsp_control_bits,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_data,
   output int                     mismatches,
   output int                     frames_waiting
);

   typedef struct packed {
      logic [ByteWidth-1:0] header;
      logic [ByteWidth-1:0] speed_one;
      logic [ByteWidth-1:0] speed_two;
      logic [CtrlWidth-1:0] ctrl;
   } drive_frame_type;

   drive_frame_type         frames_due[$];
   logic [ZoneWidth-1:0]    zone_cfg;
   logic [PercentWidth-1:0] percent_cfg;
   logic [ByteWidth-1:0]    header_cfg;
   logic                    swapped;
   logic                    button_held;

   initial begin
      mismatches     = 0;
      frames_waiting = 0;
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
      mismatches++;
   endtask

   function automatic logic [ByteWidth-1:0] scaled_speed(input int offset);
      int mag;
      int v;
      mag = (offset < 0) ? -offset : offset;
      v = (mag * 2 * int'(percent_cfg)) / 100;
      return (v > int'(SpeedMax)) ? SpeedMax : v[ByteWidth-1:0];
   endfunction

   task automatic map_poll(input logic [ByteWidth-1:0] buttons,
                           input logic [ByteWidth-1:0] stick_one,
                           input logic [ByteWidth-1:0] stick_two);
      logic            pressed;
      int              off_one;
      int              off_two;
      int              dz;
      drive_frame_type f;
      pressed = buttons[SwapBit];
      if (!button_held && pressed) begin
         swapped = !swapped;
      end
      // no sticks: no frame, button memory left alone
      if (stick_one == '0 && stick_two == '0) begin
         return;
      end
      off_one  = int'(stick_one) - int'(StickCentre);
      off_two  = int'(stick_two) - int'(StickCentre);
      dz       = int'(zone_cfg);
      f.header = header_cfg;
      f.ctrl   = CtrlIdle;
      if (!swapped) begin
         if (off_one < -dz) begin
            f.ctrl[OneRevBit] = 1'b0;
         end else if (off_one > dz) begin
            f.ctrl[OneFwdBit] = 1'b0;
         end
         if (off_two < -dz) begin
            f.ctrl[TwoRevBit] = 1'b0;
         end else if (off_two > dz) begin
            f.ctrl[TwoFwdBit] = 1'b0;
         end
         f.speed_one = scaled_speed(off_one);
         f.speed_two = scaled_speed(off_two);
      end else begin
         if (off_two > dz) begin
            f.ctrl[OneRevBit] = 1'b0;
         end else if (off_two < -dz) begin
            f.ctrl[OneFwdBit] = 1'b0;
         end
         if (off_one > dz) begin
            f.ctrl[TwoRevBit] = 1'b0;
         end else if (off_one < -dz) begin
            f.ctrl[TwoFwdBit] = 1'b0;
         end
         f.speed_one = scaled_speed(off_two);
         f.speed_two = scaled_speed(off_one);
      end
      frames_due.push_back(f);
      button_held = pressed;
   endtask

   task automatic check_frame();
      drive_frame_type want;
      if (frames_due.size() == 0) begin
         report_mismatch("frame with none due", 0, 0);
         return;
      end
      want = frames_due.pop_front();
      if (rsp_frame_header !== want.header) begin
         report_mismatch("frame_header", want.header, rsp_frame_header);
      end
      if (rsp_first_speed !== want.speed_one) begin
         report_mismatch("first_speed", want.speed_one, rsp_first_speed);
      end
      if (rsp_second_speed !== want.speed_two) begin
         report_mismatch("second_speed", want.speed_two, rsp_second_speed);
      end
      if (rsp_control_bits !== want.ctrl) begin
         report_mismatch("control_bits", want.ctrl, rsp_control_bits);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         zone_cfg    = ZoneReset;
         percent_cfg = PercentReset;
         header_cfg  = HeaderReset;
         swapped     = 1'b0;
         button_held = 1'b0;
         frames_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEAD_ZONE: begin
                  zone_cfg = csr_data[ZoneWidth-1:0];
               end
               CSR_SPEED_PERCENT: begin
                  percent_cfg = csr_data[PercentWidth-1:0];
               end
               CSR_HEADER_BYTE: begin
                  header_cfg = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            check_frame();
         end
         if (req_valid && req_stall === 1'b0) begin
            map_poll(req_button_byte, req_first_stick, req_second_stick);
         end
      end
      frames_waiting = frames_due.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import stbdm_pkg::*;

   localparam logic [CsrIdxWidth-1:0] CsrSpare = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [ByteWidth-1:0]   req_button_byte;
   logic [ByteWidth-1:0]   req_first_stick;
   logic [ByteWidth-1:0]   req_second_stick;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [ByteWidth-1:0]   rsp_frame_header;
   logic [ByteWidth-1:0]   rsp_first_speed;
   logic [ByteWidth-1:0]   rsp_second_speed;
   logic [CtrlWidth-1:0]   rsp_control_bits;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [ByteWidth-1:0]   csr_data;

   int   mismatches;
   int   frames_waiting;
   int   cur_zone;
   logic calm;
   logic steady;
   logic squeeze;

   stick_to_bridge_drive_mapper_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_byte  (req_button_byte),
      .req_first_stick  (req_first_stick),
      .req_second_stick (req_second_stick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_header (rsp_frame_header),
      .rsp_first_speed  (rsp_first_speed),
      .rsp_second_speed (rsp_second_speed),
      .rsp_control_bits (rsp_control_bits),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   drive_frame_checker frame_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_byte  (req_button_byte),
      .req_first_stick  (req_first_stick),
      .req_second_stick (req_second_stick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_header (rsp_frame_header),
      .rsp_first_speed  (rsp_first_speed),
      .rsp_second_speed (rsp_second_speed),
      .rsp_control_bits (rsp_control_bits),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .frames_waiting   (frames_waiting)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic offer_poll(input logic [ByteWidth-1:0] buttons,
                             input logic [ByteWidth-1:0] stick_one,
                             input logic [ByteWidth-1:0] stick_two);
      @(negedge clock);
      if (!calm && !steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_button_byte  <= buttons;
      req_first_stick  <= stick_one;
      req_second_stick <= stick_two;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic settle(input int quiet);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (frames_waiting == 0);
      repeat (quiet) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [ByteWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_DEAD_ZONE) begin
         cur_zone = int'(data[ZoneWidth-1:0]);
      end
   endtask

   function automatic logic [ByteWidth-1:0] pick_stick();
      int v;
      int side;
      int jitter;
      case ($urandom_range(0, 9))
         0, 1: begin
            side   = $urandom_range(0, 1) ? cur_zone : -cur_zone;
            jitter = $urandom_range(0, 2);
            v      = 127 + side + jitter - 1;
            if (v < 0) begin
               v = 0;
            end
            if (v > 255) begin
               v = 255;
            end
         end
         2: begin
            case ($urandom_range(0, 5))
               0:       v = 0;
               1:       v = 1;
               2:       v = 127;
               3:       v = 128;
               4:       v = 254;
               default: v = 255;
            endcase
         end
         default: begin
            v = $urandom_range(0, 255);
         end
      endcase
      return v[ByteWidth-1:0];
   endfunction

   task automatic run_polls(input int count, input int squeeze_at, input int calm_from);
      int                   i;
      logic [ByteWidth-1:0] buttons;
      logic [ByteWidth-1:0] stick_one;
      logic [ByteWidth-1:0] stick_two;
      for (i = 0; i < count; i++) begin
         if (i == squeeze_at) begin
            squeeze = 1'b1;
            steady  = 1'b1;
         end
         if (squeeze_at >= 0 && i == squeeze_at + 40) begin
            steady = 1'b0;
         end
         if (i == calm_from) begin
            calm = 1'b1;
         end
         buttons = $urandom_range(0, 255);
         if ($urandom_range(0, 9) == 0) begin
            stick_one = '0;
            stick_two = '0;
         end else begin
            stick_one = pick_stick();
            stick_two = pick_stick();
         end
         offer_poll(buttons, stick_one, stick_two);
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze) begin
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
            rsp_stall <= 1'b0;
            squeeze = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_button_byte  = '0;
      req_first_stick  = '0;
      req_second_stick = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_DEAD_ZONE;
      csr_data         = '0;
      calm             = 1'b0;
      steady           = 1'b0;
      squeeze          = 1'b0;
      cur_zone         = int'(ZoneReset);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer_poll(8'h00, 8'd127, 8'd127);
      offer_poll(8'h00, 8'd0,   8'd255);
      offer_poll(8'h00, 8'd255, 8'd0);
      offer_poll(8'h00, 8'd157, 8'd97);
      offer_poll(8'h00, 8'd158, 8'd96);
      offer_poll(8'h08, 8'd200, 8'd50);
      offer_poll(8'h08, 8'd50,  8'd200);
      offer_poll(8'h00, 8'd255, 8'd255);
      // held button through empty polls toggles on each
      offer_poll(8'h08, 8'd0,   8'd0);
      offer_poll(8'h08, 8'd0,   8'd0);
      offer_poll(8'h08, 8'd0,   8'd0);
      offer_poll(8'hF7, 8'd10,  8'd240);
      offer_poll(8'hFF, 8'd128, 8'd126);
      offer_poll(8'h00, 8'd0,   8'd0);
      offer_poll(8'h00, 8'd1,   8'd254);
      offer_poll(8'h08, 8'd0,   8'd0);
      offer_poll(8'h00, 8'd30,  8'd220);
      offer_poll(8'hAA, 8'd127, 8'd0);
      offer_poll(8'h55, 8'd0,   8'd127);
      settle(6);

      write_reg(CSR_DEAD_ZONE, 8'd0);
      write_reg(CSR_SPEED_PERCENT, 8'd99);
      write_reg(CSR_HEADER_BYTE, 8'h00);
      run_polls(180, -1, -1);
      settle(6);

      write_reg(CSR_DEAD_ZONE, 8'd127);
      write_reg(CSR_SPEED_PERCENT, 8'd0);
      write_reg(CSR_HEADER_BYTE, 8'hFF);
      run_polls(150, 40, -1);
      settle(6);

      // upper data bits drop; percent above 99 can saturate the speed
      write_reg(CSR_DEAD_ZONE, 8'hC8);
      write_reg(CSR_SPEED_PERCENT, 8'd127);
      write_reg(CSR_HEADER_BYTE, 8'h5A);
      write_reg(CsrSpare, 8'hFF);
      run_polls(200, -1, -1);
      settle(6);

      write_reg(CSR_DEAD_ZONE, 8'($urandom_range(0, 127)));
      write_reg(CSR_SPEED_PERCENT, 8'hE4);
      write_reg(CSR_HEADER_BYTE, 8'($urandom_range(0, 255)));
      run_polls(200, -1, -1);
      settle(6);

      write_reg(CSR_DEAD_ZONE, 8'($urandom_range(0, 255)));
      write_reg(CSR_SPEED_PERCENT, 8'($urandom_range(0, 99)));
      write_reg(CSR_HEADER_BYTE, 8'($urandom_range(0, 255)));
      run_polls(120, -1, -1);
      settle(6);

      write_reg(CSR_DEAD_ZONE, 8'd30);
      write_reg(CSR_SPEED_PERCENT, 8'd60);
      write_reg(CSR_HEADER_BYTE, 8'd173);
      run_polls(250, -1, 100);
      settle(10);

      if (mismatches == 0 && frames_waiting == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/stbdm_pkg.sv
rtl/stbdm_capture.sv
rtl/stbdm_scale.sv
rtl/stbdm_frame.sv
rtl/stick_to_bridge_drive_mapper_unit.sv
test/drive_frame_checker.sv
test/testbench.sv
